// ===== rtl/hash_stirred_entropy_pool_top_assert.svh =====
// Assertion macros for the entropy pool design.
`ifndef HASH_STIRRED_ENTROPY_POOL_TOP_ASSERT_SVH
`define HASH_STIRRED_ENTROPY_POOL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HSEP_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("hsep assertion failed");
`define HSEP_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("hsep assertion failed");
`else
`define HSEP_ASSERT(lbl, prop)
`define HSEP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/hsep_pkg.sv =====
// Types, constants and helper functions shared by the entropy pool design.
package hsep_pkg;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_GET   = 2'd1,
    KIND_MOUSE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_ADD     = 14'b00000000000010,
    S_GET_RD  = 14'b00000000000100,
    S_GET_DAT = 14'b00000000001000,
    S_IV_RD   = 14'b00000000010000,
    S_IV_DAT  = 14'b00000000100000,
    S_INIT    = 14'b00000001000000,
    S_LOAD    = 14'b00000010000000,
    S_ROUND   = 14'b00000100000000,
    S_ADDH    = 14'b00001000000000,
    S_XR_RD   = 14'b00010000000000,
    S_XR_DAT  = 14'b00100000000000,
    S_KEY_RD  = 14'b01000000000000,
    S_KEY_DAT = 14'b10000000000000
  } state_t;

  localparam logic [31:0] SHA_H0 = 32'h67452301;
  localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
  localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
  localparam logic [31:0] SHA_H3 = 32'h10325476;
  localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;
  localparam logic [31:0] SHA_K0 = 32'h5A827999;
  localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;
  localparam logic [31:0] SHA_PAD_WORD = 32'h80000000;
  localparam logic [6:0]  SHA_LAST_ROUND = 7'd79;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

endpackage

// ===== rtl/hsep_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface hsep_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] mouse_x;
  logic [31:0] mouse_y;
  logic [31:0] tick_count;
  modport source (output valid, kind, data_byte, mouse_x, mouse_y, tick_count, input ready);
  modport sink (input valid, kind, data_byte, mouse_x, mouse_y, tick_count, output ready);
endinterface

interface hsep_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] random_byte;
  modport source (output valid, random_byte, input ready);
  modport sink (input valid, random_byte, output ready);
endinterface

// ===== rtl/hsep_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hsep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/hash_stirred_entropy_pool_top.sv =====
// Entropy pool: a single byte-accumulating key, a word pool and an iterative SHA-1 stir.
// An add or mouse event mixes its bytes into the key in S_ADD; a get reads the pool in S_GET_RD, S_GET_DAT.
// A full key or an exhausted pool first triggers a stir, carried out by the single SHA-1
// round unit, which takes one round per cycle.
// One request is in flight at a time; the next is taken once the result is handed off.
// Reset is synchronous; the pool reads as zero until written, tracked by a fill count.
`include "hash_stirred_entropy_pool_top_assert.svh"
module hash_stirred_entropy_pool_top
  import hsep_pkg::*;
#(
  parameter int POOL_WORDS = 128,
  parameter int KEY_WORDS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  hsep_in_if.sink    in_ch,
  hsep_out_if.source out_ch
);
  localparam int POOL_BYTES = POOL_WORDS * 4;
  localparam int KEY_BYTES  = KEY_WORDS * 4;
  localparam int AW   = $clog2(POOL_WORDS);
  localparam int BW   = $clog2(POOL_WORDS / 4);
  localparam int GPW  = $clog2(POOL_BYTES + 1);
  localparam int APW  = $clog2(KEY_BYTES + 1);
  localparam int KIW  = $clog2(KEY_WORDS);
  localparam int MSG_BYTES = 16 + KEY_BYTES;
  localparam int SHA_BLKS  = (MSG_BYTES + 72) / 64;
  localparam int SBW  = (SHA_BLKS > 1) ? $clog2(SHA_BLKS) : 1;
  localparam int GW   = SBW + 4;
  localparam logic [31:0] MSG_BITS = 32'(MSG_BYTES * 8);

  state_t state_r, state_nxt;
  kind_t  kind_r;
  logic [95:0]  add_buf_r;
  logic [3:0]   add_cnt_r;
  logic [APW-1:0] ap_r;
  logic [GPW-1:0] gp_r;
  logic [31:0]  key_r [KEY_WORDS];
  logic [31:0]  iv_r [4];
  logic [31:0]  h_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  s_r [16];
  logic [1:0]   m_r;
  logic [BW-1:0] blk_r;
  logic [SBW-1:0] sblk_r;
  logic [3:0]   ld_r;
  logic [6:0]   rnd_r;
  logic [KIW-1:0] k_r;
  logic [AW:0]  fill_r;
  logic         rd_ok_r;
  logic         out_valid_r;
  logic [7:0]   out_byte_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata, rword;
  logic [GW-1:0] g;
  logic [31:0]   msg_word, f, kc, tmp, xr_word;
  logic          accept, pool_empty;

  hsep_ram #(.WIDTH(32), .DEPTH(POOL_WORDS)) u_pool (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_byte = out_byte_r;
  assign accept     = in_ch.valid && in_ch.ready;
  assign pool_empty = gp_r >= GPW'(POOL_BYTES);
  assign rword      = rd_ok_r ? rdata : 32'd0;
  assign xr_word    = rword ^ bswap32(h_r[m_r]);

  assign we    = (state_r == S_XR_DAT);
  assign waddr = AW'({blk_r, m_r});
  assign wdata = xr_word;

  always_comb begin
    unique case (state_r)
      S_GET_RD: raddr = gp_r[AW+1:2];
      S_IV_RD:  raddr = AW'(POOL_WORDS - 4) + AW'(m_r);
      S_XR_RD:  raddr = AW'({blk_r, m_r});
      S_KEY_RD: raddr = AW'(k_r);
      default:  raddr = '0;
    endcase
  end

  // Message word for the schedule: iv, key, padding marker, then the bit length.
  assign g = {sblk_r, ld_r};
  always_comb begin
    if (g < GW'(4)) begin
      msg_word = bswap32(iv_r[g[1:0]]);
    end else if (g < GW'(4 + KEY_WORDS)) begin
      msg_word = bswap32(key_r[KIW'(g - GW'(4))]);
    end else if (g == GW'(4 + KEY_WORDS)) begin
      msg_word = SHA_PAD_WORD;
    end else if (g == GW'(16 * SHA_BLKS - 1)) begin
      msg_word = MSG_BITS;
    end else begin
      msg_word = 32'd0;
    end
  end

  always_comb begin
    if (rnd_r < 7'd20) begin
      f  = (b_r & c_r) | (~b_r & d_r);
      kc = SHA_K0;
    end else if (rnd_r < 7'd40) begin
      f  = b_r ^ c_r ^ d_r;
      kc = SHA_K1;
    end else if (rnd_r < 7'd60) begin
      f  = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      kc = SHA_K2;
    end else begin
      f  = b_r ^ c_r ^ d_r;
      kc = SHA_K3;
    end
    tmp = {a_r[26:0], a_r[31:27]} + f + e_r + kc + s_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.kind) inside
            KIND_ADD, KIND_MOUSE: state_nxt = S_ADD;
            KIND_GET:             state_nxt = pool_empty ? S_IV_RD : S_GET_RD;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (ap_r == APW'(KEY_BYTES)) begin
          state_nxt = S_IV_RD;
        end else if (add_cnt_r == 4'd1) begin
          state_nxt = S_IDLE;
        end
      end
      S_GET_RD:  state_nxt = S_GET_DAT;
      S_GET_DAT: state_nxt = S_IDLE;
      S_IV_RD:   state_nxt = S_IV_DAT;
      S_IV_DAT:  state_nxt = (m_r == 2'd3) ? S_INIT : S_IV_RD;
      S_INIT:    state_nxt = S_LOAD;
      S_LOAD:    state_nxt = (ld_r == 4'd15) ? S_ROUND : S_LOAD;
      S_ROUND:   state_nxt = (rnd_r == SHA_LAST_ROUND) ? S_ADDH : S_ROUND;
      S_ADDH:    state_nxt = (sblk_r == SBW'(SHA_BLKS - 1)) ? S_XR_RD : S_LOAD;
      S_XR_RD:   state_nxt = S_XR_DAT;
      S_XR_DAT: begin
        if (m_r != 2'd3) begin
          state_nxt = S_XR_RD;
        end else if (blk_r == BW'(POOL_WORDS / 4 - 1)) begin
          state_nxt = S_KEY_RD;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_KEY_RD:  state_nxt = S_KEY_DAT;
      S_KEY_DAT: begin
        if (k_r == KIW'(KEY_WORDS - 1)) begin
          state_nxt = (kind_r == KIND_GET) ? S_GET_RD : S_ADD;
        end else begin
          state_nxt = S_KEY_RD;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= KIND_ADD;
      ap_r        <= '0;
      gp_r        <= GPW'(POOL_WORDS / 4);
      fill_r      <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      add_cnt_r   <= '0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rd_ok_r <= {1'b0, raddr} < fill_r;
      if (we && ({1'b0, waddr} == fill_r)) begin
        fill_r <= fill_r + 1'b1;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r <= kind_t'(in_ch.kind);
            case (in_ch.kind)
              KIND_ADD: begin
                add_buf_r <= {88'd0, in_ch.data_byte};
                add_cnt_r <= 4'd1;
              end
              KIND_MOUSE: begin
                add_buf_r <= {in_ch.tick_count, in_ch.mouse_y, in_ch.mouse_x};
                add_cnt_r <= 4'd12;
              end
              KIND_GET: m_r <= 2'd0;
              default: begin
                out_valid_r <= 1'b1;
                out_byte_r  <= 8'd0;
              end
            endcase
          end
        end
        S_ADD: begin
          if (ap_r == APW'(KEY_BYTES)) begin
            m_r <= 2'd0;
          end else begin
            key_r[ap_r[KIW+1:2]][8*ap_r[1:0] +: 8] <=
              key_r[ap_r[KIW+1:2]][8*ap_r[1:0] +: 8] ^ add_buf_r[7:0];
            ap_r      <= ap_r + 1'b1;
            gp_r      <= GPW'(POOL_BYTES);
            add_buf_r <= {8'd0, add_buf_r[95:8]};
            add_cnt_r <= add_cnt_r - 1'b1;
            if (add_cnt_r == 4'd1) begin
              out_valid_r <= 1'b1;
              out_byte_r  <= 8'd0;
            end
          end
        end
        S_GET_DAT: begin
          out_valid_r <= 1'b1;
          out_byte_r  <= rword[8*gp_r[1:0] +: 8];
          gp_r        <= gp_r + 1'b1;
        end
        S_IV_DAT: begin
          iv_r[m_r] <= rword;
          m_r       <= m_r + 1'b1;
          blk_r     <= '0;
        end
        S_INIT: begin
          h_r[0] <= SHA_H0;
          h_r[1] <= SHA_H1;
          h_r[2] <= SHA_H2;
          h_r[3] <= SHA_H3;
          h_r[4] <= SHA_H4;
          sblk_r <= '0;
          ld_r   <= '0;
        end
        S_LOAD: begin
          for (int i = 0; i < 15; i++) begin
            s_r[i] <= s_r[i+1];
          end
          s_r[15] <= msg_word;
          ld_r    <= ld_r + 1'b1;
          if (ld_r == 4'd15) begin
            rnd_r <= '0;
            a_r   <= h_r[0];
            b_r   <= h_r[1];
            c_r   <= h_r[2];
            d_r   <= h_r[3];
            e_r   <= h_r[4];
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            s_r[i] <= s_r[i+1];
          end
          s_r[15] <= rotl1(s_r[13] ^ s_r[8] ^ s_r[2] ^ s_r[0]);
          a_r   <= tmp;
          b_r   <= a_r;
          c_r   <= {b_r[1:0], b_r[31:2]};
          d_r   <= c_r;
          e_r   <= d_r;
          rnd_r <= rnd_r + 1'b1;
        end
        S_ADDH: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          sblk_r <= sblk_r + 1'b1;
          ld_r   <= '0;
          m_r    <= 2'd0;
        end
        S_XR_DAT: begin
          // The new cipher block doubles as the iv for the next block.
          iv_r[m_r] <= xr_word;
          m_r       <= m_r + 1'b1;
          if (m_r == 2'd3) begin
            blk_r <= blk_r + 1'b1;
            k_r   <= '0;
          end
        end
        S_KEY_DAT: begin
          key_r[k_r] <= rword;
          k_r        <= k_r + 1'b1;
          if (k_r == KIW'(KEY_WORDS - 1)) begin
            ap_r <= '0;
            gp_r <= GPW'(KEY_BYTES);
          end
        end
        default: begin
        end
      endcase
    end
  end

  `HSEP_ASSERT(a_add_pos_range, ap_r <= APW'(KEY_BYTES))
  `HSEP_ASSERT(a_get_pos_range, gp_r <= GPW'(POOL_BYTES))
  `HSEP_ASSERT(a_fill_range, fill_r <= (AW+1)'(POOL_WORDS))
  `HSEP_ASSERT(a_busy_after_accept, accept |=> !in_ch.ready)
  `HSEP_ASSERT(a_get_not_empty, (state_r == S_GET_RD) |-> !pool_empty)
  `HSEP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r)
endmodule

// ===== tb/sv/tb_hash_stirred_entropy_pool_top.sv =====
// Testbench for the entropy pool: random add, get and mouse requests checked against a predictor.
`timescale 1ns / 1ps
module tb_hash_stirred_entropy_pool_top;
  import hsep_pkg::*;

  localparam int POOL_BYTES = 512;
  localparam int KEY_BYTES  = 64;
  localparam int BLK        = 16;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] mouse_x;
    logic [31:0] mouse_y;
    logic [31:0] tick_count;
  } request_t;

  logic clk;
  logic rst_n;
  hsep_in_if  in_ch ();
  hsep_out_if out_ch ();

  hash_stirred_entropy_pool_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  request_t   pending_q[$];
  logic [7:0] expected_bytes_q[$];
  logic [7:0] pool_mem[POOL_BYTES];
  logic [7:0] key_mem[KEY_BYTES];
  int         add_pos;
  int         get_pos;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         errors;
  longint     cycle_count;

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Digest of a fixed 80-byte message: iv followed by the key.
  function automatic void sha1_digest(input logic [7:0] msg[BLK + KEY_BYTES],
                                      output logic [7:0] dig[20]);
    logic [7:0]  buffer[128];
    logic [31:0] h[5];
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    foreach (buffer[i]) buffer[i] = 8'h00;
    for (int i = 0; i < BLK + KEY_BYTES; i++) buffer[i] = msg[i];
    buffer[BLK + KEY_BYTES] = 8'h80;
    buffer[126] = 8'h02;
    buffer[127] = 8'h80;
    for (int blk = 0; blk < 2; blk++) begin
      for (int t = 0; t < 16; t++)
        w[t] = {buffer[blk*64+4*t], buffer[blk*64+4*t+1], buffer[blk*64+4*t+2],
                buffer[blk*64+4*t+3]};
      for (int t = 16; t < 80; t++) w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 20) begin
          f = (b & c) | (~b & d); k = 32'h5A827999;
        end else if (t < 40) begin
          f = b ^ c ^ d; k = 32'h6ED9EBA1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d; k = 32'hCA62C1D6;
        end
        tmp = rol(a, 5) + f + e + k + w[t];
        e = d; d = c; c = rol(b, 30); b = a; a = tmp;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    end
    for (int t = 0; t < 5; t++) begin
      dig[4*t] = h[t][31:24]; dig[4*t+1] = h[t][23:16];
      dig[4*t+2] = h[t][15:8]; dig[4*t+3] = h[t][7:0];
    end
  endfunction

  function automatic void stir_pool();
    logic [7:0] iv[BLK];
    logic [7:0] msg[BLK + KEY_BYTES];
    logic [7:0] dig[20];
    for (int j = 0; j < BLK; j++) iv[j] = pool_mem[POOL_BYTES - BLK + j];
    for (int i = 0; i < POOL_BYTES; i += BLK) begin
      for (int j = 0; j < BLK; j++) msg[j] = iv[j];
      for (int j = 0; j < KEY_BYTES; j++) msg[BLK + j] = key_mem[j];
      sha1_digest(msg, dig);
      for (int j = 0; j < BLK; j++) begin
        pool_mem[i+j] ^= dig[j];
        iv[j] = pool_mem[i+j];
      end
    end
    for (int j = 0; j < KEY_BYTES; j++) key_mem[j] = pool_mem[j];
    add_pos = 0;
    get_pos = KEY_BYTES;
  endfunction

  function automatic void mix_byte(logic [7:0] v);
    if (add_pos >= KEY_BYTES) stir_pool();
    key_mem[add_pos] ^= v;
    add_pos++;
    get_pos = POOL_BYTES;
  endfunction

  function automatic logic [7:0] predict_random_byte(request_t r);
    logic [7:0] res;
    res = 8'h00;
    case (r.kind)
      KIND_ADD: mix_byte(r.data_byte);
      KIND_GET: begin
        if (get_pos >= POOL_BYTES) stir_pool();
        res = pool_mem[get_pos];
        get_pos++;
      end
      KIND_MOUSE: begin
        for (int i = 0; i < 4; i++) mix_byte(r.mouse_x[8*i +: 8]);
        for (int i = 0; i < 4; i++) mix_byte(r.mouse_y[8*i +: 8]);
        for (int i = 0; i < 4; i++) mix_byte(r.tick_count[8*i +: 8]);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void queue_request(kind_t kd, logic [7:0] db, logic [31:0] mx,
                                        logic [31:0] my, logic [31:0] tc);
    request_t r;
    r.kind = kd; r.data_byte = db; r.mouse_x = mx; r.mouse_y = my; r.tick_count = tc;
    pending_q.push_back(r);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: one request at a time, held until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      expected_bytes_q.push_back(predict_random_byte(pending_q.pop_front()));
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.kind <= pending_q[0].kind;
        in_ch.data_byte <= pending_q[0].data_byte;
        in_ch.mouse_x <= pending_q[0].mouse_x;
        in_ch.mouse_y <= pending_q[0].mouse_y;
        in_ch.tick_count <= pending_q[0].tick_count;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end else if (!in_ch.valid && pending_q.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_ch.valid <= 1'b1;
      in_ch.kind <= pending_q[0].kind;
      in_ch.data_byte <= pending_q[0].data_byte;
      in_ch.mouse_x <= pending_q[0].mouse_x;
      in_ch.mouse_y <= pending_q[0].mouse_y;
      in_ch.tick_count <= pending_q[0].tick_count;
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes_q.size() == 0) begin
          $error("unexpected result: random_byte actual %0h", out_ch.random_byte);
          errors++;
        end else begin
          logic [7:0] exp_byte;
          exp_byte = expected_bytes_q.pop_front();
          if (out_ch.random_byte !== exp_byte) begin
            $error("random_byte mismatch: expected %0h actual %0h",
                   exp_byte, out_ch.random_byte);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The limit allows for a stir on every request, several times over.
  always @(posedge clk) begin
    if (cycle_count > 64'd30_000_000) begin
      $display("hash_stirred_entropy_pool_top verification failed");
      $finish;
    end
  end

  task automatic fill_random(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 35)
        queue_request(KIND_GET, 8'($urandom), $urandom, $urandom, $urandom);
      else if (roll < 75)
        queue_request(KIND_ADD, 8'($urandom), $urandom, $urandom, $urandom);
      else if (roll < 97)
        queue_request(KIND_MOUSE, 8'($urandom), $urandom, $urandom, $urandom);
      else
        queue_request(KIND_NONE, 8'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (pending_q.size() > 0 || expected_bytes_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (pool_mem[i]) pool_mem[i] = 8'h00;
    foreach (key_mem[i]) key_mem[i] = 8'h00;
    add_pos = 0;
    get_pos = 128 / 4;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_NONE;
    in_ch.data_byte = '0;
    in_ch.mouse_x = '0;
    in_ch.mouse_y = '0;
    in_ch.tick_count = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reads right after reset, extremes, the unused kind, and a key
    // that fills up and forces a stir.
    queue_request(KIND_GET, 8'h00, '0, '0, '0);
    queue_request(KIND_GET, 8'h00, '0, '0, '0);
    queue_request(KIND_NONE, 8'hFF, '1, '1, '1);
    queue_request(KIND_ADD, 8'hFF, '0, '0, '0);
    queue_request(KIND_ADD, 8'h00, '1, '1, '1);
    queue_request(KIND_GET, 8'h00, '0, '0, '0);
    queue_request(KIND_MOUSE, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_5A5A);
    queue_request(KIND_MOUSE, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
    for (int i = 0; i < 4; i++)
      queue_request(KIND_MOUSE, 8'h00, $urandom, $urandom, $urandom);
    queue_request(KIND_ADD, 8'h80, '0, '0, '0);
    queue_request(KIND_GET, 8'h00, '0, '0, '0);
    queue_request(KIND_GET, 8'h00, '0, '0, '0);
    run_phase(0, 0);

    fill_random(170);
    run_phase(0, 0);
    fill_random(170);
    run_phase(58, 0);
    fill_random(170);
    run_phase(0, 58);
    fill_random(164);
    run_phase(28, 28);
    // A long run of reads walks through the pool above the key bytes and stirs on its own.
    for (int i = 0; i < 460; i++) queue_request(KIND_GET, 8'($urandom), '0, '0, '0);
    run_phase(0, 0);

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("hash_stirred_entropy_pool_top verification clean");
    else
      $display("hash_stirred_entropy_pool_top verification failed");
    $finish;
  end

endmodule
